// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each macro is empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/core/oaht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package oaht_pkg;

    localparam int TABLE_SIZE_DEF = 64;

    localparam int KEY_W     = 31;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 6;
    localparam int COUNT_W   = 7;
    localparam int MODE_W    = 2;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

    // probe modes; the unused code probes linearly
    localparam logic [MODE_W-1:0] PM_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] PM_QUAD   = 2'd1;
    localparam logic [MODE_W-1:0] PM_DOUBLE = 2'd2;
    localparam logic [MODE_W-1:0] PM_RESET  = PM_QUAD;

    // register index, taken from paddr[2]
    localparam logic REG_PROBE_MODE = 1'b0;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  entry_count;
    } t_rsp;

    typedef struct packed {
        logic                start;
        logic                mod_step;
        logic                setup;
        logic                advance;
        logic                set_res;
        logic [STATUS_W-1:0] res_code;
        logic                res_use_slot;
        logic                write_entry;
        logic                clear_write;
        logic                load_out;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic mod_last;
        logic table_full;
        logic table_empty;
        logic slot_used;
        logic key_match;
        logic probe_last;
        logic out_free;
        logic clear_last;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/oaht_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module oaht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/oaht_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module oaht_datapath #(
    parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire oaht_pkg::t_cmd              i_cmd,
    output oaht_pkg::t_sts                   o_sts,
    input  wire oaht_pkg::t_req              i_req,
    input  wire logic [oaht_pkg::MODE_W-1:0] i_mode,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output oaht_pkg::t_rsp                   o_out_rsp
);

    import oaht_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam int EW = KEY_W + 1;
    localparam logic [AW:0] N_C = (AW + 1)'(TABLE_SIZE);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SIZE - 1);
    // floor(2^KEY_W / size): the quotient estimate is exact or one short
    localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / 64'(TABLE_SIZE));
    localparam logic [KEY_W-1:0] N_K   = KEY_W'(TABLE_SIZE);
    // modulo stages: reciprocal product, remainder estimate, correction
    localparam logic [1:0] MOD_FIRST = 2'd2;

    logic                 r_op;
    logic [KEY_W-1:0]     r_key;
    logic [AW-1:0]        r_rem;
    logic [1:0]           r_mod_phase;
    logic [KEY_W-1:0]     r_quot;
    logic [AW:0]          r_diff;
    logic [AW-1:0]        r_probe;
    logic [AW-1:0]        r_step;
    logic [AW-1:0]        r_i;
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_clr;
    logic [STATUS_W-1:0]  r_res_status;
    logic [AW-1:0]        r_res_slot;
    logic                 r_out_valid;
    t_rsp                 r_out_rsp;

    logic [2*KEY_W-1:0]   prod;
    logic [KEY_W-1:0]     diff;
    logic [AW:0]          rem_nx;
    logic [AW:0]          step_nx;
    logic [AW:0]          inc;
    logic [AW:0]          sum;
    logic [AW:0]          probe_nx;
    logic [AW-1:0]        ram_addr;
    logic                 ram_we;
    logic [EW-1:0]        ram_wdata;
    logic [EW-1:0]        ram_rdata;
    logic [SLOT_W+AW-1:0] slot_ext;
    logic [COUNT_W+CW-1:0] count_ext;
    logic                 out_free;

    // key modulo table size as a three-stage pipeline, 31 x 31 product first
    assign prod   = {{KEY_W{1'b0}}, r_key} * {{KEY_W{1'b0}}, RECIP};
    assign diff   = r_key - r_quot * N_K;
    assign rem_nx = (r_diff >= N_C) ? r_diff - N_C : r_diff;

    assign step_nx = (r_rem == '0) ? (AW + 1)'(1) : N_C - {1'b0, r_rem};

    always_comb begin
        case (i_mode)
            PM_QUAD:   inc = {1'b0, r_i} + (AW + 1)'(1);
            PM_DOUBLE: inc = {1'b0, r_step};
            default:   inc = (AW + 1)'(1);
        endcase
    end

    assign sum      = {1'b0, r_probe} + inc;
    assign probe_nx = (sum >= N_C) ? sum - N_C : sum;

    assign ram_addr  = i_cmd.clear_write ? r_clr : r_probe;
    assign ram_we    = i_cmd.write_entry | i_cmd.clear_write;
    assign ram_wdata = i_cmd.clear_write ? '0 : {1'b1, r_key};

    oaht_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts.op          = r_op;
        o_sts.mod_last    = (r_mod_phase == '0);
        o_sts.table_full  = (r_count == CW'(TABLE_SIZE));
        o_sts.table_empty = (r_count == '0);
        o_sts.slot_used   = ram_rdata[EW-1];
        o_sts.key_match   = (ram_rdata[KEY_W-1:0] == r_key);
        o_sts.probe_last  = (r_i == LAST_IDX);
        o_sts.out_free    = out_free;
        o_sts.clear_last  = (r_clr == LAST_IDX);
    end

    // narrow fields keep their low bits on wide tables
    assign slot_ext  = {{SLOT_W{1'b0}}, r_res_slot};
    assign count_ext = {{COUNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.write_entry) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.clear_write) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op        <= i_req.op;
            r_key       <= i_req.key;
            r_mod_phase <= MOD_FIRST;
        end
        if (i_cmd.mod_step) begin
            r_quot      <= prod[2*KEY_W-1:KEY_W];
            r_diff      <= diff[AW:0];
            r_rem       <= rem_nx[AW-1:0];
            r_mod_phase <= r_mod_phase - 2'd1;
        end
        if (i_cmd.setup) begin
            r_probe <= r_rem;
            r_step  <= step_nx[AW-1:0];
            r_i     <= '0;
        end
        if (i_cmd.advance) begin
            r_probe <= probe_nx[AW-1:0];
            r_i     <= r_i + AW'(1);
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_code;
            r_res_slot   <= i_cmd.res_use_slot ? r_probe : '0;
        end
        if (i_cmd.load_out) begin
            r_out_rsp.status      <= r_res_status;
            r_out_rsp.slot        <= slot_ext[SLOT_W-1:0];
            r_out_rsp.entry_count <= count_ext[COUNT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

`default_nettype wire

// ===== rtl/core/oaht_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module oaht_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire oaht_pkg::t_sts i_sts,
    output oaht_pkg::t_cmd      o_cmd
);

    import oaht_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_SETUP,
        S_READ,
        S_CHECK,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_write = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                if (i_sts.op == OP_INSERT && i_sts.table_full) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_FULL;
                    n_state        = S_FINISH;
                end else if (i_sts.op == OP_SEARCH && i_sts.table_empty) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_EMPTY;
                    n_state        = S_FINISH;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!i_sts.slot_used) begin
                    o_cmd.set_res = 1'b1;
                    n_state       = S_FINISH;
                    if (i_sts.op == OP_INSERT) begin
                        o_cmd.write_entry  = 1'b1;
                        o_cmd.res_code     = ST_INSERTED;
                        o_cmd.res_use_slot = 1'b1;
                    end else begin
                        o_cmd.res_code = ST_NOT_FOUND;
                    end
                end else if (i_sts.op == OP_SEARCH && i_sts.key_match) begin
                    o_cmd.set_res      = 1'b1;
                    o_cmd.res_code     = ST_FOUND;
                    o_cmd.res_use_slot = 1'b1;
                    n_state            = S_FINISH;
                end else if (i_sts.probe_last) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = (i_sts.op == OP_INSERT) ? ST_NO_SLOT : ST_NOT_FOUND;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

`default_nettype wire

// ===== rtl/core/open_addressing_hash_table_unit.sv =====
// Open-addressing hash table: insert or search one 31-bit key per request.
// Request channel (i_in_valid / o_in_ready, i_in_req): op selects insert or
// search, key is the key. Response channel (o_out_valid / i_out_ready,
// o_out_rsp): status, slot and the entry count after the request.
// The probe sequence (linear, triangular quadratic, double hash) is chosen by
// the probe_mode register at APB address 0; write it only while idle.
// Each request runs an accept step, the key modulo table size (reciprocal
// multiply, remainder estimate, correction), a setup step, then for each
// probed slot a registered RAM read and a compare, and last a load of the
// response register; up to TABLE_SIZE slots are probed. Full-table inserts
// and empty-table searches skip the probes and answer after setup.
// One request is in flight at a time.
// After reset the unit sweeps the slot RAM, one entry per cycle, clearing the
// valid bits with o_in_ready low until the sweep ends; APB writes still land.
// A stalled response holds in its register; the next request may be accepted
// and run, and its result waits until the held response is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module open_addressing_hash_table_unit #(
    parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire oaht_pkg::t_req              i_in_req,
    // response channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output oaht_pkg::t_rsp                   o_out_rsp,
    // APB configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [oaht_pkg::APB_AW-1:0] paddr,
    input  wire logic [oaht_pkg::APB_DW-1:0] pwdata,
    output logic      [oaht_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);

    import oaht_pkg::*;

    logic [MODE_W-1:0] r_probe_mode;
    logic              reg_sel;
    t_cmd              cmd;
    t_sts              sts;

    // ------------------------------------------------------------------
    // Configuration: single register, zero-wait APB
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_PROBE_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_mode <= PM_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_probe_mode <= pwdata[MODE_W-1:0];
        end
    end

    // read back the mode; unmapped addresses read as zero
    assign prdata = reg_sel ? {{(APB_DW - MODE_W){1'b0}}, r_probe_mode} : '0;

    // ------------------------------------------------------------------
    // Controller: sequences clearing, modulo, probes, slot writes and response load
    // ------------------------------------------------------------------
    oaht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // ------------------------------------------------------------------
    // Datapath: key registers, modulo unit, probe stepper, slot RAM,
    // entry count and the response register
    // ------------------------------------------------------------------
    oaht_datapath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_in_req),
        .i_mode      (r_probe_mode),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // drop ready right after a request is taken
    `ASSERT_CLK(a_accept_drops_ready, i_clk, i_rst_n,
                (i_in_valid && o_in_ready) |=> !o_in_ready,
                "request accepted while another is in flight")
    // an insert only ever fills an empty slot
    `ASSERT_CLK(a_write_empty_slot, i_clk, i_rst_n,
                cmd.write_entry |-> !sts.slot_used,
                "insert overwrote an occupied slot")
    // never overwrite a response that is still waiting
    `ASSERT_CLK(a_load_when_free, i_clk, i_rst_n,
                cmd.load_out |-> sts.out_free,
                "response register overwritten while stalled")
    // the clearing sweep and an insert never share the RAM write port
    `ASSERT_NEVER(a_single_writer, i_clk, i_rst_n,
                  cmd.write_entry && cmd.clear_write,
                  "insert during clearing sweep")

endmodule

`default_nettype wire

// ===== tb/open_addressing_hash_table_unit_checker.sv =====
`timescale 1ns / 1ps

module open_addressing_hash_table_unit_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  oaht_pkg::t_req              i_in_req,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  oaht_pkg::t_rsp              i_out_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [oaht_pkg::APB_AW-1:0] paddr,
    input  logic [oaht_pkg::APB_DW-1:0] pwdata,
    input  logic                        pready,
    output int                          o_mismatches,
    output int                          o_pending
);
    import oaht_pkg::*;

    localparam int SLOTS = TABLE_SIZE_DEF;

    logic [KEY_W-1:0]   stored_key [SLOTS];
    logic               occupied   [SLOTS];
    logic [COUNT_W-1:0] live_count;
    logic [MODE_W-1:0]  probe_mode;
    t_rsp               pending_answers[$];
    int                 fails = 0;
    int                 backlog = 0;

    assign o_mismatches = fails;
    assign o_pending    = backlog;

    // slot visited by probe number i from the home slot
    function automatic int probe_at(int home, int i);
        int stride;
        stride = (home == 0) ? 1 : SLOTS - home;
        case (probe_mode)
            PM_QUAD:   return (home + i * (i + 1) / 2) % SLOTS;
            PM_DOUBLE: return (home + i * stride) % SLOTS;
            default:   return (home + i) % SLOTS;
        endcase
    endfunction

    // run one insert or search against the table copy, return its answer
    function automatic t_rsp apply_table_op(t_req r);
        t_rsp ans;
        int   home;
        int   p;
        bit   done;
        home     = int'(r.key % SLOTS);
        done     = 1'b0;
        ans.slot = '0;
        if (r.op == OP_INSERT) begin
            if (live_count >= SLOTS) begin
                ans.status = ST_FULL;
            end else begin
                ans.status = ST_NO_SLOT;
                for (int i = 0; i < SLOTS && !done; i++) begin
                    p = probe_at(home, i);
                    if (!occupied[p]) begin
                        occupied[p]   = 1'b1;
                        stored_key[p] = r.key;
                        live_count++;
                        ans.status    = ST_INSERTED;
                        ans.slot      = p[SLOT_W-1:0];
                        done          = 1'b1;
                    end
                end
            end
        end else begin
            if (live_count == 0) begin
                ans.status = ST_EMPTY;
            end else begin
                ans.status = ST_NOT_FOUND;
                for (int i = 0; i < SLOTS && !done; i++) begin
                    p = probe_at(home, i);
                    if (!occupied[p]) begin
                        done = 1'b1;
                    end else if (stored_key[p] == r.key) begin
                        ans.status = ST_FOUND;
                        ans.slot   = p[SLOT_W-1:0];
                        done       = 1'b1;
                    end
                end
            end
        end
        ans.entry_count = live_count;
        return ans;
    endfunction

    task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) occupied[s] = 1'b0;
            live_count = '0;
            probe_mode = PM_RESET;
            pending_answers.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_PROBE_MODE)
                probe_mode = pwdata[MODE_W-1:0];
            // compare before predicting so a stray response is never masked
            if (i_out_valid && i_out_ready) begin
                if (pending_answers.size() == 0) begin
                    fails++;
                    $display("%0t: response with nothing expected, got status %0d slot %0d count %0d",
                             $time, i_out_rsp.status, i_out_rsp.slot, i_out_rsp.entry_count);
                end else begin
                    want = pending_answers.pop_front();
                    check_field("status", 8'(want.status), 8'(i_out_rsp.status));
                    check_field("slot", 8'(want.slot), 8'(i_out_rsp.slot));
                    check_field("entry_count", 8'(want.entry_count), 8'(i_out_rsp.entry_count));
                end
            end
            if (i_in_valid && i_in_ready)
                pending_answers.push_back(apply_table_op(i_in_req));
        end
        backlog <= pending_answers.size();
    end

endmodule

// ===== tb/open_addressing_hash_table_unit_tb.sv =====
`timescale 1ns / 1ps

module open_addressing_hash_table_unit_tb;
    import oaht_pkg::*;

    localparam logic [APB_AW-1:0] PROBE_MODE_ADDR = {REG_PROBE_MODE, 2'b00};
    // unused mode code; the block falls back to linear probing for it
    localparam logic [MODE_W-1:0] PM_SPARE        = 2'd3;
    localparam int                PHASES          = 7;
    localparam int                PHASE_REQUESTS  = 233;
    // request count at which the receiver holds off once for a long stretch
    localparam int                HOLD_AT         = 400;
    localparam int                HOLD_CYCLES     = 1200;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_req               i_in_req;
    logic               o_out_valid;
    logic               i_out_ready;
    t_rsp               o_out_rsp;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    int                 mismatches;
    int                 pending;
    int                 accepted = 0;
    int                 burst_left = 0;
    bit                 long_hold_done = 1'b0;
    // every key ever sent as an insert; searches draw on it to hit stored keys
    logic [KEY_W-1:0]   placed_keys[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    open_addressing_hash_table_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    open_addressing_hash_table_unit_checker table_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_req     (i_in_req),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_rsp    (o_out_rsp),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Offer one request and hold it until the block takes it. Afterwards either
    // keep valid high for the next request of the burst, or drop it for a gap.
    task automatic offer(logic req_op, logic [KEY_W-1:0] req_key);
        i_in_valid <= 1'b1;
        i_in_req   <= {req_op, req_key};
        do @(posedge i_clk); while (!o_in_ready);
        accepted++;
        if (req_op == OP_INSERT) placed_keys.push_back(req_key);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            // mostly short gaps; now and then one long enough to span a whole probe run
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6))
                @(posedge i_clk);
            // occasionally a long burst with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Drop valid and wait until every request has been answered.
    task automatic go_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_probe_mode(logic [MODE_W-1:0] mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PROBE_MODE_ADDR;
        pwdata  <= APB_DW'(mode);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Keys: fully random, crowded onto a few home slots so probe chains grow
    // long, the two extremes, or small values.
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4, 5: begin
                case ($urandom_range(0, 3))
                    0: k[SLOT_W-1:0] = 6'd0;
                    1: k[SLOT_W-1:0] = 6'd1;
                    2: k[SLOT_W-1:0] = 6'd32;
                    default: k[SLOT_W-1:0] = 6'd63;
                endcase
            end
            6: k = $urandom_range(0, 1) ? {KEY_W{1'b1}} : '0;
            default: k[KEY_W-1:8] = '0;
        endcase
        return k;
    endfunction

    // One random request: inserts at the given percentage (some of them
    // duplicates), searches half the time for a key already sent.
    task automatic random_request(int insert_pct);
        logic [KEY_W-1:0] k;
        if ($urandom_range(0, 99) < insert_pct) begin
            if (placed_keys.size() > 0 && $urandom_range(0, 7) == 0)
                k = placed_keys[$urandom_range(0, placed_keys.size() - 1)];
            else
                k = pick_key();
            offer(OP_INSERT, k);
        end else begin
            if (placed_keys.size() > 0 && $urandom_range(0, 1) == 1)
                k = placed_keys[$urandom_range(0, placed_keys.size() - 1)];
            else
                k = pick_key();
            offer(OP_SEARCH, k);
        end
    endtask

    // Probe mode of each random phase; every code is visited, extremes included.
    function automatic logic [MODE_W-1:0] phase_mode(int ph);
        case (ph)
            0: return PM_DOUBLE;
            1: return PM_SPARE;
            2: return PM_QUAD;
            3: return PM_DOUBLE;
            4: return PM_LINEAR;
            5: return PM_QUAD;
            default: return PM_DOUBLE;
        endcase
    endfunction

    // Request side: reset, directed requests, random phases, verdict.
    initial begin : request_side
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_req   <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset mode is quadratic; search the empty table at both key extremes
        offer(OP_SEARCH, '0);
        offer(OP_SEARCH, {KEY_W{1'b1}});
        // pile keys onto home 0: slots 0, 1, 3, then a duplicate of 0 at slot 6
        offer(OP_INSERT, 31'd0);
        offer(OP_INSERT, 31'd64);
        offer(OP_INSERT, 31'd128);
        offer(OP_INSERT, 31'd0);
        // home 63 and a wrap past the end of the table
        offer(OP_INSERT, {KEY_W{1'b1}});
        offer(OP_INSERT, 31'd63);
        offer(OP_SEARCH, 31'd0);
        offer(OP_SEARCH, 31'd128);
        offer(OP_SEARCH, 31'd192);
        offer(OP_SEARCH, {KEY_W{1'b1}});
        offer(OP_SEARCH, 31'd63);
        offer(OP_SEARCH, 31'd1);

        // double hash from home 32 only reaches slots 32 and 0: the second
        // insert finds no free probe slot and the search runs out of probes
        go_idle();
        write_probe_mode(PM_DOUBLE);
        offer(OP_INSERT, 31'd32);
        offer(OP_INSERT, 31'd96);
        offer(OP_SEARCH, 31'd96);
        offer(OP_INSERT, 31'd5);
        offer(OP_INSERT, 31'd69);
        offer(OP_SEARCH, 31'd69);

        // Sparse inserts first, then a linear phase that fills the table,
        // then searches and rejected inserts against the full table.
        for (int ph = 0; ph < PHASES; ph++) begin
            go_idle();
            write_probe_mode(phase_mode(ph));
            repeat (PHASE_REQUESTS) random_request((ph == 4) ? 35 : 5);
        end

        go_idle();
        // allow a full probe run for any response that should not come
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("open_addressing_hash_table_unit: match");
        else
            $display("open_addressing_hash_table_unit: mismatch");
        $finish;
    end

    // Response side: stall on a pattern of random runs; once, hold off long
    // enough that the block parks a response, finishes the next request and
    // backs up into its input while requests keep coming.
    initial begin : response_side
        int run;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!long_hold_done && accepted >= HOLD_AT) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold_done = 1'b1;
            end
            run = $urandom_range(1, 60);
            case ($urandom_range(0, 3))
                0: begin
                    i_out_ready <= 1'b1;
                    repeat (run) @(posedge i_clk);
                end
                1: repeat (run) begin
                    i_out_ready <= 1'($urandom_range(0, 1));
                    @(posedge i_clk);
                end
                2: begin
                    i_out_ready <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
                default: repeat (run) begin
                    i_out_ready <= ~i_out_ready;
                    @(posedge i_clk);
                end
            endcase
        end
    end

    // hard stop well past the slowest correct run
    initial begin : run_limit
        #20_000_000;
        $display("open_addressing_hash_table_unit: mismatch");
        $finish;
    end

endmodule

// ===== open_addressing_hash_table_unit.f =====
+incdir+rtl/core
rtl/core/oaht_pkg.sv
rtl/core/oaht_ram.sv
rtl/core/oaht_datapath.sv
rtl/core/oaht_ctrl.sv
rtl/core/open_addressing_hash_table_unit.sv
tb/open_addressing_hash_table_unit_checker.sv
tb/open_addressing_hash_table_unit_tb.sv
